// ----- sv/csc_pkg.sv -----
// ----------------------------------------------------------------------------
// csc_pkg
// Shared types, character codes, class codes and classification functions
// for the C source byte classifier.
// ----------------------------------------------------------------------------
package csc_pkg;

    typedef logic [7:0] t_char;
    typedef logic [5:0] t_cls;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // characters
    localparam t_char CH_UPPER_A = 8'h41;
    localparam t_char CH_UPPER_Z = 8'h5A;
    localparam t_char CH_LOWER_A = 8'h61;
    localparam t_char CH_LOWER_Z = 8'h7A;
    localparam t_char CH_DIGIT_0 = 8'h30;
    localparam t_char CH_DIGIT_9 = 8'h39;
    localparam t_char CH_UNDER   = 8'h5F;
    localparam t_char CH_SPACE   = 8'h20;
    localparam t_char CH_NL      = 8'h0A;
    localparam t_char CH_TAB     = 8'h09;
    localparam t_char CH_PLUS    = 8'h2B;
    localparam t_char CH_MINUS   = 8'h2D;
    localparam t_char CH_DOT     = 8'h2E;
    localparam t_char CH_LPAREN  = 8'h28;
    localparam t_char CH_RPAREN  = 8'h29;
    localparam t_char CH_LBRACK  = 8'h5B;
    localparam t_char CH_RBRACK  = 8'h5D;
    localparam t_char CH_LBRACE  = 8'h7B;
    localparam t_char CH_RBRACE  = 8'h7D;
    localparam t_char CH_TILDE   = 8'h7E;
    localparam t_char CH_BANG    = 8'h21;
    localparam t_char CH_STAR    = 8'h2A;
    localparam t_char CH_SLASH   = 8'h2F;
    localparam t_char CH_PCT     = 8'h25;
    localparam t_char CH_LT      = 8'h3C;
    localparam t_char CH_GT      = 8'h3E;
    localparam t_char CH_EQ      = 8'h3D;
    localparam t_char CH_AMP     = 8'h26;
    localparam t_char CH_CARET   = 8'h5E;
    localparam t_char CH_PIPE    = 8'h7C;
    localparam t_char CH_COMMA   = 8'h2C;
    localparam t_char CH_SEMI    = 8'h3B;
    localparam t_char CH_SQUOTE  = 8'h27;
    localparam t_char CH_DQUOTE  = 8'h22;

    // terminal classes
    localparam t_cls CLS_SKIP      = 6'd0;
    localparam t_cls CLS_LETTER    = 6'd1;
    localparam t_cls CLS_NUMBER    = 6'd2;
    localparam t_cls CLS_INC       = 6'd3;
    localparam t_cls CLS_PLUS      = 6'd4;
    localparam t_cls CLS_DEC       = 6'd5;
    localparam t_cls CLS_ARROW     = 6'd6;
    localparam t_cls CLS_MINUS     = 6'd7;
    localparam t_cls CLS_DOT       = 6'd8;
    localparam t_cls CLS_LPAREN    = 6'd9;
    localparam t_cls CLS_RPAREN    = 6'd10;
    localparam t_cls CLS_LBRACK    = 6'd11;
    localparam t_cls CLS_RBRACK    = 6'd12;
    localparam t_cls CLS_LBRACE    = 6'd13;
    localparam t_cls CLS_RBRACE    = 6'd14;
    localparam t_cls CLS_BIT_NOT   = 6'd15;
    localparam t_cls CLS_NOT_EQ    = 6'd16;
    localparam t_cls CLS_LOG_NOT   = 6'd17;
    localparam t_cls CLS_STAR      = 6'd18;
    localparam t_cls CLS_DIV       = 6'd19;
    localparam t_cls CLS_MOD       = 6'd20;
    localparam t_cls CLS_LSHIFT    = 6'd21;
    localparam t_cls CLS_LESS_EQ   = 6'd22;
    localparam t_cls CLS_LESS      = 6'd23;
    localparam t_cls CLS_RSHIFT    = 6'd24;
    localparam t_cls CLS_GREATER_EQ = 6'd25;
    localparam t_cls CLS_GREATER   = 6'd26;
    localparam t_cls CLS_EQ_EQ     = 6'd27;
    localparam t_cls CLS_ASSIGN    = 6'd28;
    localparam t_cls CLS_LOG_AND   = 6'd29;
    localparam t_cls CLS_AND       = 6'd30;
    localparam t_cls CLS_BIT_XOR   = 6'd31;
    localparam t_cls CLS_LOG_OR    = 6'd32;
    localparam t_cls CLS_BIT_OR    = 6'd33;
    localparam t_cls CLS_COMMA     = 6'd34;
    localparam t_cls CLS_END_STMT  = 6'd35;
    localparam t_cls CLS_SQUOTE    = 6'd36;
    localparam t_cls CLS_DQUOTE    = 6'd37;
    localparam t_cls CLS_NONE      = 6'd38;

    // results caused by one input byte, as queued between front and back
    typedef struct packed {
        logic two;    // two results, else one
        t_cls cls0;
        t_cls cls1;
        logic last;   // byte was the final one of the text
    } t_run;

    function automatic t_cls single_class(input t_char c);
        t_cls r;
        r = CLS_NONE;
        if ((c >= CH_UPPER_A && c <= CH_UPPER_Z) || (c >= CH_LOWER_A && c <= CH_LOWER_Z) ||
            c == CH_UNDER) begin
            r = CLS_LETTER;
        end else if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) begin
            r = CLS_NUMBER;
        end else begin
            case (c)
                CH_SPACE, CH_NL, CH_TAB: r = CLS_SKIP;
                CH_PLUS:   r = CLS_PLUS;
                CH_MINUS:  r = CLS_MINUS;
                CH_DOT:    r = CLS_DOT;
                CH_LPAREN: r = CLS_LPAREN;
                CH_RPAREN: r = CLS_RPAREN;
                CH_LBRACK: r = CLS_LBRACK;
                CH_RBRACK: r = CLS_RBRACK;
                CH_LBRACE: r = CLS_LBRACE;
                CH_RBRACE: r = CLS_RBRACE;
                CH_TILDE:  r = CLS_BIT_NOT;
                CH_BANG:   r = CLS_LOG_NOT;
                CH_STAR:   r = CLS_STAR;
                CH_SLASH:  r = CLS_DIV;
                CH_PCT:    r = CLS_MOD;
                CH_LT:     r = CLS_LESS;
                CH_GT:     r = CLS_GREATER;
                CH_EQ:     r = CLS_ASSIGN;
                CH_AMP:    r = CLS_AND;
                CH_CARET:  r = CLS_BIT_XOR;
                CH_PIPE:   r = CLS_BIT_OR;
                CH_COMMA:  r = CLS_COMMA;
                CH_SEMI:   r = CLS_END_STMT;
                CH_SQUOTE: r = CLS_SQUOTE;
                CH_DQUOTE: r = CLS_DQUOTE;
                default:   r = CLS_NONE;
            endcase
        end
        return r;
    endfunction

    function automatic logic is_starter(input t_char c);
        return c == CH_PLUS || c == CH_MINUS || c == CH_BANG || c == CH_LT || c == CH_GT ||
               c == CH_EQ || c == CH_AMP || c == CH_PIPE || c == CH_SLASH;
    endfunction

    // combined class of a two-byte operator, skip when the bytes form none
    function automatic t_cls pair_class(input t_char a, input t_char b);
        t_cls r;
        r = CLS_SKIP;
        case (a)
            CH_PLUS:  if (b == CH_PLUS) r = CLS_INC;
            CH_MINUS: begin
                if (b == CH_MINUS) r = CLS_DEC;
                else if (b == CH_GT) r = CLS_ARROW;
            end
            CH_BANG:  if (b == CH_EQ) r = CLS_NOT_EQ;
            CH_LT: begin
                if (b == CH_LT) r = CLS_LSHIFT;
                else if (b == CH_EQ) r = CLS_LESS_EQ;
            end
            CH_GT: begin
                if (b == CH_GT) r = CLS_RSHIFT;
                else if (b == CH_EQ) r = CLS_GREATER_EQ;
            end
            CH_EQ:    if (b == CH_EQ) r = CLS_EQ_EQ;
            CH_AMP:   if (b == CH_AMP) r = CLS_LOG_AND;
            CH_PIPE:  if (b == CH_PIPE) r = CLS_LOG_OR;
            default:  r = CLS_SKIP;
        endcase
        return r;
    endfunction

endpackage

// ----- sv/csc_if.sv -----
// ----------------------------------------------------------------------------
// csc_if
// Request channels of the C source byte classifier: text bytes in,
// terminal classes out.
// ----------------------------------------------------------------------------
interface csc_byte_if;
    logic             valid;
    logic             ready;
    csc_pkg::t_char   char_byte;
    logic             last_byte;

    modport source (output valid, output char_byte, output last_byte, input ready);
    modport sink   (input valid, input char_byte, input last_byte, output ready);
endinterface

interface csc_class_if;
    logic             valid;
    logic             ready;
    csc_pkg::t_cls    token_class;
    logic             last_of_run;
    logic             end_of_text;

    modport source (output valid, output token_class, output last_of_run,
                    output end_of_text, input ready);
    modport sink   (input valid, input token_class, input last_of_run,
                    input end_of_text, output ready);
endinterface

// ----- sv/csc_front.sv -----
// ----------------------------------------------------------------------------
// csc_front
// Accepts text bytes, tracks the held operator byte and line comments, and
// pushes the results of each byte, if it has any, as one queue entry.
// ----------------------------------------------------------------------------
module csc_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    csc_byte_if.sink        i_in,
    input  logic            i_full,
    output logic            o_push,
    output csc_pkg::t_run   o_run
);
    import csc_pkg::*;

    logic  r_held;
    t_char r_hchar;
    logic  r_comment;
    logic  n_held;
    t_char n_hchar;
    logic  n_comment;

    logic  w_accept;
    logic  w_done;
    logic  w_any;
    t_cls  w_pc;
    t_char w_c;

    assign i_in.ready = !i_full;
    assign w_accept   = i_in.valid && !i_full;
    assign w_c        = i_in.char_byte;
    assign w_pc       = pair_class(r_hchar, w_c);

    always_comb begin
        n_held    = r_held;
        n_hchar   = r_hchar;
        n_comment = r_comment;
        w_done    = 1'b0;
        w_any     = 1'b0;
        o_run     = '{two: 1'b0, cls0: CLS_SKIP, cls1: CLS_SKIP, last: i_in.last_byte};

        if (r_comment) begin
            w_any  = 1'b1;
            w_done = 1'b1;
            if (w_c == CH_NL) n_comment = 1'b0;
        end else if (r_held) begin
            n_held  = 1'b0;
            n_hchar = '0;
            w_any   = 1'b1;
            if (w_pc != CLS_SKIP) begin
                o_run.cls0 = w_pc;
                o_run.two  = 1'b1;
                w_done     = 1'b1;
            end else if (r_hchar == CH_SLASH && w_c == CH_SLASH) begin
                o_run.two  = 1'b1;
                n_comment  = 1'b1;
                w_done     = 1'b1;
            end else begin
                o_run.cls0 = single_class(r_hchar);
            end
        end

        if (!w_done) begin
            if (is_starter(w_c) && !i_in.last_byte) begin
                n_held  = 1'b1;
                n_hchar = w_c;
            end else if (w_any) begin
                // flushed held byte comes first, this byte second
                o_run.cls1 = single_class(w_c);
                o_run.two  = 1'b1;
            end else begin
                o_run.cls0 = single_class(w_c);
                w_any      = 1'b1;
            end
        end

        if (i_in.last_byte) begin
            n_held    = 1'b0;
            n_hchar   = '0;
            n_comment = 1'b0;
        end
    end

    assign o_push = w_accept && w_any;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held    <= 1'b0;
            r_hchar   <= '0;
            r_comment <= 1'b0;
        end else if (w_accept) begin
            r_held    <= n_held;
            r_hchar   <= n_hchar;
            r_comment <= n_comment;
        end
    end

endmodule

// ----- sv/csc_queue.sv -----
// ----------------------------------------------------------------------------
// csc_queue
// Short first-in first-out queue of result entries between front and back.
// ----------------------------------------------------------------------------
module csc_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  csc_pkg::t_run   i_run,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_valid,
    output csc_pkg::t_run   o_head
);
    import csc_pkg::*;

    t_run              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_cnt;
    logic              w_pop;

    assign o_full  = r_cnt == QCNT_W'(QUEUE_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_head  = r_mem[r_rd];
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_run;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= (r_wr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            if (w_pop)  r_rd <= (r_rd == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            case ({i_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ----- sv/csc_back.sv -----
// ----------------------------------------------------------------------------
// csc_back
// Takes queue entries and sends their results one request at a time through
// a registered output stage.
// ----------------------------------------------------------------------------
module csc_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  csc_pkg::t_run   i_head,
    output logic            o_pop,
    csc_class_if.source     o_out
);
    import csc_pkg::*;

    logic r_ovalid;
    logic r_sub;
    t_cls r_cls;
    logic r_lor;
    logic r_eot;
    logic w_load;
    logic w_first;

    assign w_load  = !r_ovalid || o_out.ready;
    // first of a pair goes out without closing the entry
    assign w_first = !r_sub && i_head.two;
    assign o_pop   = w_load && i_valid && !w_first;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_sub    <= 1'b0;
        end else if (w_load) begin
            r_ovalid <= i_valid;
            if (i_valid) r_sub <= w_first;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load && i_valid) begin
            r_cls <= r_sub ? i_head.cls1 : i_head.cls0;
            r_lor <= !w_first;
            r_eot <= !w_first && i_head.last;
        end
    end

    assign o_out.valid       = r_ovalid;
    assign o_out.token_class = r_cls;
    assign o_out.last_of_run = r_lor;
    assign o_out.end_of_text = r_eot;

endmodule

// ----- sv/c_source_char_classifier.sv -----
// Path: a byte's results are written as one queue entry when it is accepted, then
// loaded into the output register; a held operator byte waits for the next byte.
// Throughput: one byte per cycle in while the queue has room; one result per cycle out
// while the receiver is ready, from the single output register; paired results go in turn.
// Reset: synchronous, active low; clears the held byte, the comment flag,
// the queue and the output stage.
// ----------------------------------------------------------------------------
// c_source_char_classifier
// Classifies C source text one byte per request into terminal classes,
// combining two-character operators and skipping line comments.
// ----------------------------------------------------------------------------
module c_source_char_classifier (
    input  logic        i_clk,
    input  logic        i_rst_n,
    csc_byte_if.sink    i_in,
    csc_class_if.source o_out
);
    import csc_pkg::*;

    logic w_full;
    logic w_push;
    t_run w_run;
    logic w_pop;
    logic w_qvalid;
    t_run w_head;

    csc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_run   (w_run)
    );

    csc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_run   (w_run),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_valid (w_qvalid),
        .o_head  (w_head)
    );

    csc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_qvalid),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

endmodule

// ----- tb/csc_class_checker.sv -----
// ----------------------------------------------------------------------------
// csc_class_checker
// Watches the byte and class channels of the C source byte classifier,
// predicts the terminal class of every byte and compares each result
// field by field, in order.
// ----------------------------------------------------------------------------
module csc_class_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    csc_byte_if   i_bytes,
    csc_class_if  i_classes,
    output int    o_fail_count,
    output int    o_pending
);
    import csc_pkg::*;

    typedef struct packed {
        t_cls cls;
        logic run_end;
        logic text_end;
    } t_class_result;

    t_class_result class_expected_q[$];

    // predictor state
    logic  pend_valid;
    t_char pend_char;
    logic  comment_on;
    int    fails;

    function automatic t_cls byte_class(input t_char c);
        t_cls  k;
        t_char folded;
        folded = c | 8'h20;
        case (c)
            CH_SPACE, CH_NL, CH_TAB: k = CLS_SKIP;
            CH_PLUS:   k = CLS_PLUS;
            CH_MINUS:  k = CLS_MINUS;
            CH_DOT:    k = CLS_DOT;
            CH_LPAREN: k = CLS_LPAREN;
            CH_RPAREN: k = CLS_RPAREN;
            CH_LBRACK: k = CLS_LBRACK;
            CH_RBRACK: k = CLS_RBRACK;
            CH_LBRACE: k = CLS_LBRACE;
            CH_RBRACE: k = CLS_RBRACE;
            CH_TILDE:  k = CLS_BIT_NOT;
            CH_BANG:   k = CLS_LOG_NOT;
            CH_STAR:   k = CLS_STAR;
            CH_SLASH:  k = CLS_DIV;
            CH_PCT:    k = CLS_MOD;
            CH_LT:     k = CLS_LESS;
            CH_GT:     k = CLS_GREATER;
            CH_EQ:     k = CLS_ASSIGN;
            CH_AMP:    k = CLS_AND;
            CH_CARET:  k = CLS_BIT_XOR;
            CH_PIPE:   k = CLS_BIT_OR;
            CH_COMMA:  k = CLS_COMMA;
            CH_SEMI:   k = CLS_END_STMT;
            CH_SQUOTE: k = CLS_SQUOTE;
            CH_DQUOTE: k = CLS_DQUOTE;
            default: begin
                // case folding maps upper to lower letters, nothing else lands there
                if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) k = CLS_NUMBER;
                else if (c == CH_UNDER || (folded >= CH_LOWER_A && folded <= CH_LOWER_Z))
                    k = CLS_LETTER;
                else k = CLS_NONE;
            end
        endcase
        return k;
    endfunction

    function automatic logic opens_pair(input t_char c);
        case (c)
            CH_PLUS, CH_MINUS, CH_BANG, CH_LT, CH_GT,
            CH_EQ, CH_AMP, CH_PIPE, CH_SLASH: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    // skip means the two bytes make no operator
    function automatic t_cls pair_of(input t_char a, input t_char b);
        case ({a, b})
            {CH_PLUS, CH_PLUS}:   return CLS_INC;
            {CH_MINUS, CH_MINUS}: return CLS_DEC;
            {CH_MINUS, CH_GT}:    return CLS_ARROW;
            {CH_BANG, CH_EQ}:     return CLS_NOT_EQ;
            {CH_LT, CH_LT}:       return CLS_LSHIFT;
            {CH_LT, CH_EQ}:       return CLS_LESS_EQ;
            {CH_GT, CH_GT}:       return CLS_RSHIFT;
            {CH_GT, CH_EQ}:       return CLS_GREATER_EQ;
            {CH_EQ, CH_EQ}:       return CLS_EQ_EQ;
            {CH_AMP, CH_AMP}:     return CLS_LOG_AND;
            {CH_PIPE, CH_PIPE}:   return CLS_LOG_OR;
            default:              return CLS_SKIP;
        endcase
    endfunction

    task automatic classify_byte(input t_char c, input logic fin);
        t_cls          got[2];
        int            n;
        logic          done;
        t_cls          pc;
        t_class_result r;
        n = 0;
        done = 1'b0;
        if (comment_on) begin
            got[0] = CLS_SKIP;
            n = 1;
            if (c == CH_NL) comment_on = 1'b0;
            done = 1'b1;
        end else if (pend_valid) begin
            pc = pair_of(pend_char, c);
            pend_valid = 1'b0;
            if (pc != CLS_SKIP) begin
                got[0] = pc;
                got[1] = CLS_SKIP;
                n = 2;
                done = 1'b1;
            end else if (pend_char == CH_SLASH && c == CH_SLASH) begin
                got[0] = CLS_SKIP;
                got[1] = CLS_SKIP;
                n = 2;
                comment_on = 1'b1;
                done = 1'b1;
            end else begin
                got[0] = byte_class(pend_char);
                n = 1;
            end
            pend_char = '0;
        end
        if (!done) begin
            // a possible operator start waits for the next byte unless the text ends
            if (opens_pair(c) && !fin) begin
                pend_valid = 1'b1;
                pend_char = c;
            end else begin
                got[n] = byte_class(c);
                n++;
            end
        end
        for (int i = 0; i < n; i++) begin
            r.cls = got[i];
            r.run_end = (i == n - 1);
            r.text_end = fin && (i == n - 1);
            class_expected_q.push_back(r);
        end
        if (fin) begin
            pend_valid = 1'b0;
            pend_char = '0;
            comment_on = 1'b0;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_class_result want;
        if (!i_rst_n) begin
            pend_valid = 1'b0;
            pend_char = '0;
            comment_on = 1'b0;
            class_expected_q.delete();
        end else begin
            if (i_classes.valid && i_classes.ready) begin
                if (class_expected_q.size() == 0) begin
                    $error("result with none waiting: token_class %0d", i_classes.token_class);
                    fails++;
                end else begin
                    want = class_expected_q.pop_front();
                    if (i_classes.token_class !== want.cls) begin
                        $error("token_class expected %0d actual %0d",
                               want.cls, i_classes.token_class);
                        fails++;
                    end
                    if (i_classes.last_of_run !== want.run_end) begin
                        $error("last_of_run expected %0b actual %0b",
                               want.run_end, i_classes.last_of_run);
                        fails++;
                    end
                    if (i_classes.end_of_text !== want.text_end) begin
                        $error("end_of_text expected %0b actual %0b",
                               want.text_end, i_classes.end_of_text);
                        fails++;
                    end
                end
            end
            if (i_bytes.valid && i_bytes.ready)
                classify_byte(i_bytes.char_byte, i_bytes.last_byte);
        end
        o_pending <= class_expected_q.size();
        o_fail_count <= fails;
    end

    initial begin
        fails = 0;
        o_fail_count = 0;
        o_pending = 0;
    end

endmodule

// ----- tb/c_source_char_classifier_test.sv -----
// ----------------------------------------------------------------------------
// c_source_char_classifier_test
// Feeds the classifier directed and random C-like text with bursty requests
// and a stalling receiver, and reports the verdict from the checker.
// ----------------------------------------------------------------------------
module c_source_char_classifier_test;
    import csc_pkg::*;

    typedef struct {
        t_char c;
        logic  fin;
    } t_text_byte;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;

    t_text_byte text_q[$];

    csc_byte_if  byte_ch ();
    csc_class_if class_ch ();

    c_source_char_classifier uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (byte_ch),
        .o_out   (class_ch)
    );

    csc_class_checker class_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_bytes      (byte_ch),
        .i_classes    (class_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    task automatic add_byte(input t_char c, input logic fin);
        t_text_byte b;
        b.c = c;
        b.fin = fin;
        text_q.push_back(b);
    endtask

    task automatic build_random_text(input int goal);
        t_char starters[9];
        t_char puncts[17];
        int    len;
        starters = '{CH_PLUS, CH_MINUS, CH_BANG, CH_LT, CH_GT, CH_EQ, CH_AMP, CH_PIPE,
                     CH_SLASH};
        puncts = '{CH_DOT, CH_LPAREN, CH_RPAREN, CH_LBRACK, CH_RBRACK, CH_LBRACE,
                   CH_RBRACE, CH_TILDE, CH_STAR, CH_PCT, CH_CARET, CH_COMMA, CH_SEMI,
                   CH_SQUOTE, CH_DQUOTE, CH_SPACE, CH_NL};
        while (text_q.size() < goal) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    len = $urandom_range(1, 5);
                    repeat (len) begin
                        case ($urandom_range(0, 3))
                            0: add_byte(t_char'($urandom_range(CH_LOWER_A, CH_LOWER_Z)), 1'b0);
                            1: add_byte(t_char'($urandom_range(CH_UPPER_A, CH_UPPER_Z)), 1'b0);
                            2: add_byte(CH_UNDER, 1'b0);
                            default:
                                add_byte(t_char'($urandom_range(CH_DIGIT_0, CH_DIGIT_9)), 1'b0);
                        endcase
                    end
                end
                2: begin
                    len = $urandom_range(1, 3);
                    repeat (len)
                        add_byte(t_char'($urandom_range(CH_DIGIT_0, CH_DIGIT_9)), 1'b0);
                end
                3: begin
                    // two starters in a row, a real operator or not
                    add_byte(starters[$urandom_range(0, 8)], 1'b0);
                    add_byte(starters[$urandom_range(0, 8)], 1'b0);
                end
                4: add_byte(puncts[$urandom_range(0, 16)], 1'b0);
                5: begin
                    case ($urandom_range(0, 2))
                        0: add_byte(CH_SPACE, 1'b0);
                        1: add_byte(CH_TAB, 1'b0);
                        default: add_byte(CH_NL, 1'b0);
                    endcase
                end
                6: begin
                    add_byte(CH_SLASH, 1'b0);
                    add_byte(CH_SLASH, 1'b0);
                    len = $urandom_range(0, 6);
                    repeat (len) add_byte(t_char'($urandom_range(0, 255)), 1'b0);
                    add_byte(CH_NL, 1'b0);
                end
                7: add_byte(t_char'($urandom_range(0, 255)), 1'b0);
                8: begin
                    // end of text, often on a byte that would otherwise be held
                    if ($urandom_range(0, 1) == 1)
                        add_byte(starters[$urandom_range(0, 8)], 1'b1);
                    else add_byte(t_char'($urandom_range(0, 255)), 1'b1);
                end
                default: begin
                    add_byte(starters[$urandom_range(0, 8)], 1'b0);
                    add_byte(t_char'($urandom_range(0, 127)), 1'b0);
                end
            endcase
        end
        text_q[text_q.size() - 1].fin = 1'b1;
    endtask

    task automatic send_byte(input t_text_byte b);
        byte_ch.valid <= 1'b1;
        byte_ch.char_byte <= b.c;
        byte_ch.last_byte <= b.fin;
        @(posedge i_clk);
        while (!byte_ch.ready) @(posedge i_clk);
    endtask

    // receiver: changing stall pattern, with one long hold-off to back the block up
    initial begin : receiver
        int cycle;
        int mode;
        cycle = 0;
        mode = 0;
        class_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            cycle++;
            if (cycle % 64 == 0) mode = $urandom_range(0, 2);
            if (cycle >= 300 && cycle < 520) class_ch.ready <= 1'b0;
            else begin
                case (mode)
                    0: class_ch.ready <= 1'b1;
                    1: class_ch.ready <= ($urandom_range(0, 1) == 1);
                    default: class_ch.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
            @(posedge i_clk);
        end
    end

    initial begin : sender
        int idx;
        int burst;
        int gap;
        byte_ch.valid <= 1'b0;
        byte_ch.char_byte <= '0;
        byte_ch.last_byte <= 1'b0;
        i_rst_n <= 1'b0;

        // extremes, a few operator pairs, a comment and the end-of-text cases
        add_byte(8'h00, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(CH_UPPER_A, 1'b0);
        add_byte(CH_LOWER_Z, 1'b0);
        add_byte(CH_UNDER, 1'b0);
        add_byte(CH_DIGIT_9, 1'b0);
        add_byte(CH_TAB, 1'b0);
        add_byte(CH_MINUS, 1'b0);
        add_byte(CH_GT, 1'b0);
        add_byte(CH_BANG, 1'b0);
        add_byte(CH_EQ, 1'b0);
        add_byte(CH_PLUS, 1'b0);
        add_byte(CH_LOWER_A, 1'b0);
        add_byte(CH_SLASH, 1'b0);
        add_byte(CH_SLASH, 1'b0);
        add_byte(8'hC3, 1'b0);
        add_byte(CH_NL, 1'b0);
        add_byte(CH_AMP, 1'b0);
        add_byte(CH_PIPE, 1'b0);
        add_byte(CH_PIPE, 1'b0);
        add_byte(CH_LT, 1'b1);
        add_byte(CH_EQ, 1'b0);
        add_byte(CH_EQ, 1'b1);
        add_byte(CH_SLASH, 1'b0);
        add_byte(CH_SLASH, 1'b1);
        build_random_text(text_q.size() + 450);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        idx = 0;
        while (idx < text_q.size()) begin
            burst = $urandom_range(1, 16);
            while (burst > 0 && idx < text_q.size()) begin
                send_byte(text_q[idx]);
                idx++;
                burst--;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            if (gap > 0) begin
                byte_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        byte_ch.valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("c_source_char_classifier test passed");
        end else begin
            $display("c_source_char_classifier test failed");
        end
        $finish;
    end

    initial begin : watchdog
        #2000000;
        $display("c_source_char_classifier test failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/csc_pkg.sv
sv/csc_if.sv
sv/csc_front.sv
sv/csc_queue.sv
sv/csc_back.sv
sv/c_source_char_classifier.sv
tb/csc_class_checker.sv
tb/c_source_char_classifier_test.sv
